[hdl/icfm_pkg.sv]
// Shared types and constants of the input capture frequency meter.
// Used by icfm_div and input_capture_frequency_meter; depends on nothing else.
`default_nettype none

package icfm_pkg;

  // Width of the configuration registers and of the frequency result.
  localparam int REG_W = 24;

  // Configuration port: index width and register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_RELOAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK_RATE      = 2'd1;

  // Register values after reset.
  localparam logic [REG_W-1:0] RELOAD_RESET = 24'hFF_FFFF;
  localparam logic [REG_W-1:0] TICK_RESET   = 24'd1_000_000;

  // Defaults of the top-level parameters.
  localparam int CHANNELS_DEFAULT       = 2;
  localparam int TIMESTAMP_BITS_DEFAULT = 24;

  // Control sequencer of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PERIOD,
    ST_SUM,
    ST_DIV,
    ST_OUT
  } state_t;

  // Command and status of the serial divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

[hdl/icfm_div.sv]
// Radix-2 restoring divider that produces one quotient bit per cycle.
// Depends on icfm_pkg for the register width and the control structs.
`default_nettype none

module icfm_div #(
  parameter int PW = icfm_pkg::REG_W + 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire icfm_pkg::div_ctl_t         ctl,
  input  wire logic [icfm_pkg::REG_W-1:0] dividend,
  input  wire logic [PW-1:0]              divisor,
  output logic      [icfm_pkg::REG_W-1:0] quotient,
  output icfm_pkg::div_sts_t              sts
);

  localparam int QW    = icfm_pkg::REG_W;
  localparam int CNT_W = $clog2(QW + 1);
  localparam int TW    = (PW > QW + 1) ? PW : QW + 1;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [QW-1:0]    quo_r, quo_nxt;
  logic [QW-1:0]    rem_r, rem_nxt;
  logic [PW-1:0]    dsr_r, dsr_nxt;

  logic [TW-1:0]    trial;
  logic [TW-1:0]    trial_diff;
  logic             fits;

  // The partial remainder stays below the divisor and below 2**QW, so the
  // shifted value needs only one extra bit.
  always_comb begin
    trial      = TW'({rem_r, quo_r[QW-1]});
    fits       = (trial >= TW'(dsr_r));
    trial_diff = trial - TW'(dsr_r);
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (ctl.start) begin
      cnt_nxt  = CNT_W'(QW);
      busy_nxt = 1'b1;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[QW-2:0], fits};
      rem_nxt = fits ? trial_diff[QW-1:0] : trial[QW-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

[hdl/input_capture_frequency_meter.sv]
// Top level of the input capture frequency meter; uses icfm_pkg and icfm_div.
// A closing-edge request walks through the period, sum, divide (skipped for a zero
// period) and output states before out_tvalid rises; no new request is taken until the
// result is loaded, which waits while an earlier result is not taken; an opening-edge
// request leaves it idle. Reset (rst_n low, synchronous) clears all phases, stored times
// and last frequencies, and loads counter_reload = 0xFFFFFF and tick_rate = 1000000.
`default_nettype none

module input_capture_frequency_meter #(
  parameter int CHANNELS       = icfm_pkg::CHANNELS_DEFAULT,
  parameter int TIMESTAMP_BITS = icfm_pkg::TIMESTAMP_BITS_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  // Capture event requests.
  input  wire logic                                   in_tvalid,
  output logic                                        in_tready,
  // tdata: timestamp [TIMESTAMP_BITS-1:0], zero padding above.
  input  wire logic [((TIMESTAMP_BITS+7)/8)*8-1:0]    in_tdata,
  // tuser: channel [0].
  input  wire logic                                   in_tuser,
  // Measurement results.
  output logic                                        out_tvalid,
  input  wire logic                                   out_tready,
  // tdata: frequency [23:0].
  output logic      [icfm_pkg::REG_W-1:0]             out_tdata,
  // tuser: out_channel [0], error [1].
  output logic      [1:0]                             out_tuser,
  // Configuration writes.
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [icfm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [icfm_pkg::REG_W-1:0]             cfg_data
);

  localparam int REG_W = icfm_pkg::REG_W;
  localparam int TS_W  = TIMESTAMP_BITS;
  // Common width for comparing a timestamp with the reload value.
  localparam int HW    = (TS_W > REG_W) ? TS_W : REG_W;
  // The wrapped period is a head term plus a timestamp, one bit wider.
  localparam int PW    = HW + 1;
  localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers. Writes are accepted in every cycle; the host
  // must write only while the meter is idle, which the block does not enforce.
  logic [REG_W-1:0] reload_r;
  logic [REG_W-1:0] tick_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reload_r <= icfm_pkg::RELOAD_RESET;
      tick_r   <= icfm_pkg::TICK_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        icfm_pkg::CFG_COUNTER_RELOAD: reload_r <= cfg_data;
        icfm_pkg::CFG_TICK_RATE:      tick_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-channel state: phase, time of the first edge, last good frequency.
  logic             phase_r   [CHANNELS];
  logic [TS_W-1:0]  first_r   [CHANNELS];
  logic [REG_W-1:0] last_fr_r [CHANNELS];

  // Work registers of the measurement in flight.
  icfm_pkg::state_t state_r, state_nxt;
  logic [CH_W-1:0]  idx_r;
  logic             ch_r;
  logic [TS_W-1:0]  ts_r;
  logic [TS_W-1:0]  first_w_r;
  logic [REG_W-1:0] last_w_r;
  logic [TS_W-1:0]  diff_r;
  logic [REG_W-1:0] head_r;
  logic             later_r;
  logic             earlier_r;
  logic             err_r;
  logic [REG_W-1:0] freq_r;

  // Result register; it parts the sequencer from the downstream side.
  logic             out_valid_r;
  logic [REG_W-1:0] out_freq_r;
  logic             out_ch_r;
  logic             out_err_r;

  // Request decode.
  logic            in_acc;
  logic            ch_ok;
  logic [CH_W-1:0] in_idx;
  logic [TS_W-1:0] in_ts;

  assign in_idx = CH_W'(in_tuser);
  assign in_ts  = in_tdata[TS_W-1:0];
  // Channel 1 does not exist in a single-channel build; such edges are dropped.
  assign ch_ok  = (CHANNELS > 1) || !in_tuser;
  assign in_acc = in_tvalid && in_tready;

  // Period arithmetic, one stage per state.
  logic [HW-1:0] first_ext;
  logic [HW-1:0] reload_ext;
  logic [HW-1:0] head_full;
  logic [PW-1:0] period_nxt;

  always_comb begin
    first_ext  = HW'(first_w_r);
    reload_ext = HW'(reload_r);
    // Ticks from the first edge up to the reload value; none if the first
    // edge already lay at or above it.
    head_full  = (reload_ext > first_ext) ? (reload_ext - first_ext) : '0;
    if (later_r) begin
      period_nxt = PW'(diff_r);
    end else if (earlier_r) begin
      period_nxt = PW'(head_r) + PW'(ts_r);
    end else begin
      period_nxt = '0;
    end
  end

  // Divider. It latches the period in the same cycle that it is summed.
  icfm_pkg::div_ctl_t div_ctl;
  icfm_pkg::div_sts_t div_sts;
  logic [REG_W-1:0]   div_quo;

  icfm_div #(
    .PW(PW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (tick_r),
    .divisor  (period_nxt),
    .quotient (div_quo),
    .sts      (div_sts)
  );

  // Sequencer: a closing edge walks through period, sum, divide and output.
  // A zero period skips the divider and reports an error.
  logic out_load;

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    div_ctl.start = 1'b0;
    out_load      = 1'b0;
    case (state_r)
      icfm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && ch_ok && phase_r[in_idx]) begin
          state_nxt = icfm_pkg::ST_PERIOD;
        end
      end
      icfm_pkg::ST_PERIOD: begin
        state_nxt = icfm_pkg::ST_SUM;
      end
      icfm_pkg::ST_SUM: begin
        if (period_nxt == '0) begin
          state_nxt = icfm_pkg::ST_OUT;
        end else begin
          div_ctl.start = 1'b1;
          state_nxt     = icfm_pkg::ST_DIV;
        end
      end
      icfm_pkg::ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = icfm_pkg::ST_OUT;
        end
      end
      icfm_pkg::ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = icfm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = icfm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= icfm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Channel state: the phase flips on every accepted edge of a valid
  // channel; the last frequency changes only with a good measurement.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_r[i]   <= 1'b0;
        first_r[i]   <= '0;
        last_fr_r[i] <= '0;
      end
    end else begin
      if (in_acc && ch_ok) begin
        phase_r[in_idx] <= !phase_r[in_idx];
        if (!phase_r[in_idx]) begin
          first_r[in_idx] <= in_ts;
        end
      end
      if (out_load && !err_r) begin
        last_fr_r[idx_r] <= freq_r;
      end
    end
  end

  // Measurement datapath.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      idx_r     <= in_idx;
      ch_r      <= in_tuser;
      ts_r      <= in_ts;
      first_w_r <= first_r[in_idx];
      last_w_r  <= last_fr_r[in_idx];
    end
    if (state_r == icfm_pkg::ST_PERIOD) begin
      later_r   <= (ts_r > first_w_r);
      earlier_r <= (ts_r < first_w_r);
      diff_r    <= ts_r - first_w_r;
      head_r    <= head_full[REG_W-1:0];
    end
    if (state_r == icfm_pkg::ST_SUM) begin
      err_r    <= (period_nxt == '0);
      freq_r   <= last_w_r;
    end
    if (div_sts.done) begin
      freq_r <= div_quo;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_freq_r <= freq_r;
      out_ch_r   <= ch_r;
      out_err_r  <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_freq_r;
  assign out_tuser  = {out_err_r, out_ch_r};

`ifndef SYNTH
  // The divider finishes only while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == icfm_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  // A new division never starts on top of one in progress.
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");

  // Every accepted edge of a valid channel flips that channel's phase.
  a_phase_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ch_ok) |=> (phase_r[$past(in_idx)] != $past(phase_r[in_idx])))
    else $error("channel phase did not toggle");

  // A zero period is flagged as an error and skips the divider.
  a_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == icfm_pkg::ST_SUM) && (period_nxt == '0))
      |=> (err_r && (state_r == icfm_pkg::ST_OUT)))
    else $error("zero period not reported as error");
`endif

endmodule

`default_nettype wire
